@@ rtl/totp_pkg.sv @@
`default_nettype none
package totp_pkg;

  localparam int KeyBytesMaxDef = 20;
  localparam int WindowMaxDef   = 7;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 64;
  localparam int CodeW          = 27;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegKey0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey1   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey2   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKeyLen = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDigits = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPeriod = 3'd5;

  // Request kinds.
  localparam logic FuncCompute = 1'b0;
  localparam logic FuncVerify  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the request and start the window walk
    logic step_init; // prepare the time value of the current offset
    logic div_start; // start the time / period division
    logic div_step;  // one bit of the division
    logic blk_init;  // load chaining value and message words for a block
    logic round;     // one SHA-1 round
    logic blk_fold;  // add the working state into the chaining value
    logic mod_start; // start the truncation and decimal reduction
    logic mod_step;  // one bit of the reduction
    logic next_off;  // advance to the next offset
    logic [1:0] blk; // which of the four blocks
  } totp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic invalid;   // zero key length or zero period
    logic verify;    // request is a verify
    logic skip;      // offset falls below time zero
    logic last_off;  // current offset is the last one
    logic match;     // code equals the candidate
    logic div_done;
    logic mod_done;
    logic round_last;
  } totp_sts_t;

  localparam logic [31:0] ShaH0 = 32'h67452301;
  localparam logic [31:0] ShaH1 = 32'hEFCDAB89;
  localparam logic [31:0] ShaH2 = 32'h98BADCFE;
  localparam logic [31:0] ShaH3 = 32'h10325476;
  localparam logic [31:0] ShaH4 = 32'hC3D2E1F0;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

endpackage
`default_nettype wire

@@ rtl/totp_ctrl.sv @@
`default_nettype none
module totp_ctrl (
  input  wire  logic             clk,
  input  wire  logic             rst_n,
  input  wire  logic             in_fire,
  output logic                   busy,
  output logic                   res_valid,
  input  wire  logic             out_ready,
  output totp_pkg::totp_cmd_t    cmd,
  input  wire  totp_pkg::totp_sts_t sts
);
  import totp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_STEP, S_DIV, S_BINIT, S_ROUND, S_FOLD, S_MOD, S_CMP, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] blk_r, blk_nxt;

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    blk_nxt   = blk_r;
    cmd       = '0;
    cmd.blk   = blk_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.invalid) state_nxt = S_OUT;
        else state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.step_init = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        // After STEP, the first divide step latches the offset time; a skip is handled here.
        if (sts.skip) begin
          cmd.next_off = 1'b1;
          state_nxt    = S_STEP;
        end else if (sts.div_done) begin
          blk_nxt   = 2'd0;
          state_nxt = S_BINIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_BINIT: begin
        cmd.blk_init = 1'b1;
        state_nxt    = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (sts.round_last) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.blk_fold = 1'b1;
        if (blk_r == 2'd3) begin
          cmd.mod_start = 1'b1;
          state_nxt     = S_MOD;
        end else begin
          blk_nxt   = blk_r + 2'd1;
          state_nxt = S_BINIT;
        end
      end
      S_MOD: begin
        if (sts.mod_done) state_nxt = S_CMP;
        else cmd.mod_step = 1'b1;
      end
      S_CMP: begin
        if (!sts.verify || sts.match || sts.last_off) begin
          state_nxt = S_OUT;
        end else begin
          cmd.next_off = 1'b1;
          state_nxt    = S_STEP;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_STEP) cmd.div_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      blk_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      blk_r   <= blk_nxt;
    end
  end

  ap_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.round && cmd.div_step)) else $error("round and divide at once");
  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !out_ready |=> res_valid) else $error("result dropped");
  ap_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && out_ready |=> !busy) else $error("not idle after result");
endmodule
`default_nettype wire

@@ rtl/totp_dp.sv @@
`default_nettype none
module totp_dp #(
  parameter int KEY_BYTES_MAX = totp_pkg::KeyBytesMaxDef,
  parameter int WINDOW_MAX    = totp_pkg::WindowMaxDef
) (
  input  wire  logic                         clk,
  input  wire  logic                         rst_n,
  input  wire  logic                         cfg_we,
  input  wire  logic [totp_pkg::CfgIdxW-1:0] cfg_index,
  input  wire  logic [totp_pkg::CfgDataW-1:0] cfg_data,
  input  wire  logic                         req_func,
  input  wire  logic [63:0]                  req_time,
  input  wire  logic [2:0]                   req_window,
  input  wire  logic [26:0]                  req_cand,
  input  wire  totp_pkg::totp_cmd_t          cmd,
  output totp_pkg::totp_sts_t                sts,
  output logic [26:0]                        res_code,
  output logic                               res_matched,
  output logic                               res_status
);
  import totp_pkg::*;

  localparam int WinW  = (WINDOW_MAX < 1) ? 1 : $clog2(WINDOW_MAX + 1);
  localparam int OffW  = WinW + 2;
  localparam int KLenMax = (KEY_BYTES_MAX > 20) ? 20 : KEY_BYTES_MAX;

  // Configuration registers.
  logic [63:0] key0_r, key1_r;
  logic [31:0] key2_r;
  logic [4:0]  klen_r;
  logic [3:0]  digits_r;
  logic [31:0] period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0; key1_r <= '0; key2_r <= '0;
      klen_r <= '0; digits_r <= 4'd6; period_r <= 32'd30;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegKey0:   key0_r   <= cfg_data;
        RegKey1:   key1_r   <= cfg_data;
        RegKey2:   key2_r   <= cfg_data[31:0];
        RegKeyLen: klen_r   <= cfg_data[4:0];
        RegDigits: digits_r <= cfg_data[3:0];
        RegPeriod: period_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Key padded to a 512-bit block, bytes beyond the length zeroed.
  logic [159:0] key_raw;
  logic [511:0] key_blk;
  logic [4:0]   klen_eff;
  assign key_raw  = {key0_r, key1_r, key2_r};
  assign klen_eff = (klen_r > 5'(KLenMax)) ? 5'(KLenMax) : klen_r;
  always_comb begin
    key_blk = '0;
    for (int i = 0; i < 20; i++) begin
      if (5'(i) < klen_eff) key_blk[511-8*i -: 8] = key_raw[159-8*i -: 8];
    end
  end

  // Request registers.
  logic        func_r;
  logic [63:0] time_r;
  logic [26:0] cand_r;
  logic [WinW-1:0] win_r;
  logic [OffW-1:0] k_r;
  logic        match_r;

  logic [WinW-1:0] win_clamp;
  assign win_clamp = (32'(req_window) > WINDOW_MAX) ? WinW'(WINDOW_MAX) : WinW'(req_window);

  // Offset time: distance = |k - win| * period, built once per offset.
  logic [OffW-1:0] step_span;
  logic            below;
  logic [63:0]     dprod_r;
  logic            skip_r;
  assign below     = (k_r < OffW'(win_r));
  assign step_span = below ? (OffW'(win_r) - k_r) : (k_r - OffW'(win_r));

  // Divider: counter = tt / period, restoring, one bit a cycle.
  logic [63:0] quo_r;
  logic [32:0] rem_r;
  logic [6:0]  dcnt_r;
  logic [32:0] rem_sh;
  assign rem_sh = {rem_r[31:0], quo_r[63]};

  // SHA-1 state.
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] w_r [16];
  logic [6:0]  rnd_r;
  logic [159:0] inner_r;
  logic [511:0] blk_words;

  always_comb begin
    unique case (cmd.blk)
      2'd0: blk_words = key_blk ^ {64{8'h36}};
      2'd1: blk_words = {quo_r, 8'h80, 376'd0, 64'd576};
      2'd2: blk_words = key_blk ^ {64{8'h5C}};
      default: blk_words = {inner_r, 8'h80, 280'd0, 64'd672};
    endcase
  end

  logic [31:0] f_v, k_v, tmp_v, wn_v;
  always_comb begin
    if (rnd_r < 7'd20) begin
      f_v = (b_r & c_r) | (~b_r & d_r); k_v = 32'h5A827999;
    end else if (rnd_r < 7'd40) begin
      f_v = b_r ^ c_r ^ d_r; k_v = 32'h6ED9EBA1;
    end else if (rnd_r < 7'd60) begin
      f_v = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k_v = 32'h8F1BBCDC;
    end else begin
      f_v = b_r ^ c_r ^ d_r; k_v = 32'hCA62C1D6;
    end
    tmp_v = rotl(a_r, 5) + f_v + e_r + k_v + w_r[0];
    wn_v  = rotl(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0], 1);
  end

  // Truncation and reduction modulo 10^digits (digits clamped to 6..8), one bit a cycle.
  logic [31:0] bin_r;
  logic [27:0] mrem_r;
  logic [5:0]  mcnt_r;
  logic [26:0] code_cur;
  logic [26:0] modv;
  logic [3:0]  dsel;
  logic [159:0] dig;
  logic [3:0]  toff;
  logic [31:0] bin_v;
  logic [27:0] mrem_sh;

  assign dsel = (digits_r < 4'd6) ? 4'd6 : ((digits_r > 4'd8) ? 4'd8 : digits_r);
  always_comb begin
    unique case (dsel)
      4'd6: modv = 27'd1000000;
      4'd7: modv = 27'd10000000;
      default: modv = 27'd100000000;
    endcase
  end
  assign dig   = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};
  assign toff  = dig[3:0];
  assign bin_v = dig[159 - 8*toff -: 32] & 32'h7FFFFFFF;
  assign mrem_sh = {mrem_r[26:0], bin_r[31]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= req_func;
      time_r  <= req_time;
      cand_r  <= req_cand;
      win_r   <= (req_func == FuncVerify) ? win_clamp : '0;
      k_r     <= '0;
      match_r <= 1'b0;
      // A new request starts with no finished reduction.
      mcnt_r  <= '0;
    end
    if (cmd.next_off) k_r <= k_r + OffW'(1);
    if (cmd.step_init) begin
      dprod_r <= 64'(step_span) * 64'(period_r);
    end
    // Division setup is registered at the same edge as the product.
    if (cmd.div_start) begin
      skip_r <= 1'b0;
      dcnt_r <= '0;
      rem_r  <= '0;
    end
    if (cmd.div_step) begin
      if (dcnt_r == 7'd0) begin
        // First step only latches the offset time and the skip flag.
        skip_r <= below && (dprod_r > time_r);
        quo_r  <= below ? time_r - dprod_r : time_r + dprod_r;
        dcnt_r <= 7'd1;
      end else begin
        if (rem_sh >= {1'b0, period_r}) begin
          rem_r <= rem_sh - {1'b0, period_r};
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[62:0], 1'b0};
        end
        dcnt_r <= dcnt_r + 7'd1;
      end
    end
    if (cmd.blk_init) begin
      if (cmd.blk == 2'd0 || cmd.blk == 2'd2) begin
        h_r[0] <= ShaH0; h_r[1] <= ShaH1; h_r[2] <= ShaH2;
        h_r[3] <= ShaH3; h_r[4] <= ShaH4;
        a_r <= ShaH0; b_r <= ShaH1; c_r <= ShaH2; d_r <= ShaH3; e_r <= ShaH4;
      end else begin
        a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
      end
      for (int i = 0; i < 16; i++) w_r[i] <= blk_words[511-32*i -: 32];
      rnd_r <= '0;
    end
    if (cmd.round) begin
      e_r <= d_r; d_r <= c_r; c_r <= rotl(b_r, 30); b_r <= a_r; a_r <= tmp_v;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn_v;
      rnd_r <= rnd_r + 7'd1;
    end
    if (cmd.blk_fold) begin
      h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
      h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
      if (cmd.blk == 2'd1) begin
        inner_r <= {h_r[0] + a_r, h_r[1] + b_r, h_r[2] + c_r, h_r[3] + d_r, h_r[4] + e_r};
      end
    end
    if (cmd.mod_start) begin
      mcnt_r <= '0;
      mrem_r <= '0;
    end
    if (cmd.mod_step) begin
      if (mcnt_r == 6'd0) begin
        bin_r <= bin_v;
      end else begin
        if (mrem_sh >= {1'b0, modv}) mrem_r <= mrem_sh - {1'b0, modv};
        else mrem_r <= mrem_sh;
        bin_r <= {bin_r[30:0], 1'b0};
      end
      mcnt_r <= mcnt_r + 6'd1;
    end
  end

  assign code_cur = mrem_r[26:0];

  assign sts.invalid    = (klen_r == 5'd0) || (period_r == 32'd0);
  assign sts.verify     = (func_r == FuncVerify);
  assign sts.skip       = skip_r && (dcnt_r == 7'd1);
  assign sts.last_off   = (k_r == OffW'({win_r, 1'b0}));
  assign sts.match      = (code_cur == cand_r);
  assign sts.div_done   = (dcnt_r == 7'd65) && !skip_r;
  assign sts.mod_done   = (mcnt_r == 6'd33);
  assign sts.round_last = (rnd_r == 7'd79);

  // Match flag kept for the result.
  logic matched_r;
  always_ff @(posedge clk) begin
    if (cmd.load) matched_r <= 1'b0;
    else if (sts.verify && sts.mod_done && sts.match) matched_r <= 1'b1;
  end

  assign res_status  = sts.invalid;
  assign res_code    = (sts.invalid || sts.verify) ? '0 : code_cur;
  assign res_matched = !sts.invalid && sts.verify && matched_r;

  ap_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round |-> rnd_r < 7'd80) else $error("round counter overrun");
  ap_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_step && (mcnt_r == 6'd32) |=> mrem_r < {1'b0, modv})
    else $error("remainder out of range");
  ap_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.next_off |-> k_r < OffW'({win_r, 1'b0})) else $error("offset past window");
endmodule
`default_nettype wire

@@ rtl/totp_hmac_sha1_engine.sv @@
// Each time step runs setup, the divide, four SHA-1 blocks, the reduction and a compare;
// a request is checked first and ends in an output state; a skipped step leaves the divide after its first step.
// Verify repeats the step for up to 2*window+1 offsets and stops at the first match.
// Throughput: one request at a time; the next is taken the cycle after the result is taken.
// Reset (rst_n, synchronous, active low) returns the controller to idle and loads
// the register defaults: key zero, key length 0, 6 digits, 30-second period.
`default_nettype none
module totp_hmac_sha1_engine #(
  parameter int KEY_BYTES_MAX = totp_pkg::KeyBytesMaxDef,
  parameter int WINDOW_MAX    = totp_pkg::WindowMaxDef
) (
  input  wire  logic                          clk,
  input  wire  logic                          rst_n,
  input  wire  logic                          cfg_we,
  input  wire  logic [totp_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire  logic [totp_pkg::CfgDataW-1:0] cfg_data,
  input  wire  logic                          in_tvalid,
  output logic                                in_tready,
  // time_sec[63:0], window[66:64], candidate_code[93:67], zero fill
  input  wire  logic [95:0]                   in_tdata,
  // func
  input  wire  logic                          in_tuser,
  output logic                                out_tvalid,
  input  wire  logic                          out_tready,
  // otp_code[26:0], matched[27], status[28], zero fill
  output logic [31:0]                         out_tdata
);
  import totp_pkg::*;

  totp_cmd_t   cmd;
  totp_sts_t   sts;
  logic        busy, in_fire;
  logic [26:0] res_code;
  logic        res_matched, res_status;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_tdata = {3'd0, res_status, res_matched, res_code};

  totp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .busy(busy),
    .res_valid(out_tvalid), .out_ready(out_tready), .cmd(cmd), .sts(sts)
  );

  totp_dp #(.KEY_BYTES_MAX(KEY_BYTES_MAX), .WINDOW_MAX(WINDOW_MAX)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req_func(in_tuser), .req_time(in_tdata[63:0]),
    .req_window(in_tdata[66:64]), .req_cand(in_tdata[93:67]), .cmd(cmd),
    .sts(sts), .res_code(res_code), .res_matched(res_matched), .res_status(res_status)
  );
endmodule
`default_nettype wire
